### rtl/otlt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// otlt_pkg: shared types for the owner-tagged lock table
// Operation codes and the packed request and response beats.
// ----------------------------------------------------------------------------
package otlt_pkg;

  localparam int unsigned RES_W   = 4;
  localparam int unsigned OWNER_W = 16;

  typedef enum logic [1:0] {
    KIND_CLAIM   = 2'd0,
    KIND_FREE    = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_QUERY   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [RES_W-1:0]   resource;
    logic [OWNER_W-1:0] caller_id;
  } in_t;

  typedef struct packed {
    logic               refused;
    logic               locked_for_caller;
    logic [OWNER_W-1:0] owner;
  } out_t;

endpackage
`default_nettype wire

### rtl/owner_tagged_lock_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owner_tagged_lock_table: table of resource locks tagged with an owner id
// Claim, free, release-all-by-owner and query on a table held in flip-flops.
// ----------------------------------------------------------------------------
// An accepted input beat passes through the input register, then the result
// register, to its result beat.
// Throughput: one beat per cycle while the result beat is taken; the table
// update and the parallel owner compare of release-all are both combinational.
// Reset: synchronous, active low; it empties the pipeline and clears every
// locked flag and every stored owner id.
module owner_tagged_lock_table
  import otlt_pkg::*;
#(
  parameter int unsigned NUM_RESOURCES = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  // Index width for the table and a common width to bring the request's
  // resource field and the index together.
  localparam int unsigned IDX_W = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
  localparam int unsigned EXT_W = (IDX_W > RES_W) ? IDX_W : RES_W;

  // Input register stage.
  logic s1_valid_r;
  in_t  s1_data_r;

  // Result register stage.
  logic out_valid_r;
  out_t out_data_r;

  // Lock table state.
  logic [NUM_RESOURCES-1:0] flags_r;
  logic [NUM_RESOURCES-1:0] flags_nxt;
  logic [OWNER_W-1:0]       owners_r   [NUM_RESOURCES];
  logic [OWNER_W-1:0]       owners_nxt [NUM_RESOURCES];

  // The item in the input stage moves on whenever the result register is
  // empty or its beat is being taken this cycle.
  logic s1_adv;
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  // Decode of the held request.
  logic [EXT_W-1:0]   res_ext;
  logic [IDX_W-1:0]   idx;
  logic               in_range;
  logic [OWNER_W-1:0] who;
  logic               cur_flag;
  logic [OWNER_W-1:0] cur_owner;
  logic               new_flag;
  logic [OWNER_W-1:0] new_owner;
  logic               entry_we;
  logic               refused;
  out_t               result;

  assign res_ext  = EXT_W'(s1_data_r.resource);
  assign idx      = res_ext[IDX_W-1:0];
  assign in_range = 32'(s1_data_r.resource) < 32'(NUM_RESOURCES);
  assign who      = s1_data_r.caller_id;

  // Only entries reachable through the resource field are read here; the
  // out-of-range case is masked below, so the read value there is harmless.
  assign cur_flag  = flags_r[idx];
  assign cur_owner = owners_r[idx];

  // Work out the state of the addressed entry after the operation, and
  // whether the entry itself is to be written.
  always_comb begin
    new_flag  = cur_flag;
    new_owner = cur_owner;
    entry_we  = 1'b0;
    refused   = 1'b0;
    unique case (s1_data_r.kind)
      KIND_CLAIM: begin
        // A claim is refused only when the resource is out of range or another owner
        // holds the entry; the system id gets no privilege here.
        if (!in_range || (cur_flag && (cur_owner != who))) begin
          refused = 1'b1;
        end else begin
          new_flag  = 1'b1;
          new_owner = who;
          entry_we  = 1'b1;
        end
      end
      KIND_FREE: begin
        // A free on an unlocked entry succeeds and changes nothing.
        if (!in_range) begin
          refused = 1'b1;
        end else if (cur_flag) begin
          if ((cur_owner == who) || (who == '0)) begin
            new_flag = 1'b0;
            entry_we = 1'b1;
          end else begin
            refused = 1'b1;
          end
        end
      end
      KIND_RELEASE: begin
        // The table-wide clear below also covers the addressed entry.
        if (cur_owner == who) begin
          new_flag = 1'b0;
        end
      end
      KIND_QUERY: begin
      end
      default: begin
      end
    endcase
  end

  // Result beat: the addressed entry as it stands after the operation. A
  // nonzero caller sees its own lock as free; an unlocked entry reads owner 0.
  always_comb begin
    result.refused = refused;
    if (in_range) begin
      result.locked_for_caller = new_flag && !((new_owner == who) && (who != '0));
      result.owner             = new_flag ? new_owner : '0;
    end else begin
      result.locked_for_caller = 1'b0;
      result.owner             = '0;
    end
  end

  // Next table state. Release-all compares every stored owner in parallel,
  // locked or not; claim and free write the single addressed entry.
  always_comb begin
    for (int i = 0; i < NUM_RESOURCES; i++) begin
      flags_nxt[i]  = flags_r[i];
      owners_nxt[i] = owners_r[i];
      if (s1_adv) begin
        if ((s1_data_r.kind == KIND_RELEASE) && (owners_r[i] == who)) begin
          flags_nxt[i] = 1'b0;
        end
        if (entry_we && (idx == IDX_W'(i))) begin
          flags_nxt[i]  = new_flag;
          owners_nxt[i] = new_owner;
        end
      end
    end
  end

  // Control and table registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
      for (int i = 0; i < NUM_RESOURCES; i++) begin
        owners_r[i] <= '0;
      end
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      flags_r <= flags_nxt;
      for (int i = 0; i < NUM_RESOURCES; i++) begin
        owners_r[i] <= owners_nxt[i];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A claim that was granted leaves its entry locked.
  a_claim_locks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_data_r.kind == KIND_CLAIM) && !refused) |=> flags_r[$past(idx)])
    else $error("granted claim did not lock its entry");

  // A query never changes the table.
  a_query_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_data_r.kind == KIND_QUERY)) |=> (flags_r == $past(flags_r)))
    else $error("query changed the lock flags");

  // Only claim and free can be refused.
  a_refuse_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && ((s1_data_r.kind == KIND_RELEASE) || (s1_data_r.kind == KIND_QUERY)))
      |=> !out_data_r.refused)
    else $error("release-all or query reported refused");

  // With the result register empty the block always takes a new beat.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled while result register empty");

endmodule
`default_nettype wire
